[design/burst_reassembly_tracker_macros.svh]
// Assertion helpers shared by the tracker
`ifndef BURST_REASSEMBLY_TRACKER_MACROS_SVH
`define BURST_REASSEMBLY_TRACKER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define BRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define BRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/brt_pkg.sv]
package brt_pkg;

   // Input commands
   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_FIRST   = 3'd0;
   localparam cmd_type CMD_DATA    = 3'd1;
   localparam cmd_type CMD_END     = 3'd2;
   localparam cmd_type CMD_VERDICT = 3'd3;
   localparam cmd_type CMD_QUIET   = 3'd4;

   // Result kinds
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_ASSEMBLE = 3'd0;
   localparam kind_type KIND_FIRST    = 3'd1;
   localparam kind_type KIND_MISSING  = 3'd2;
   localparam kind_type KIND_RESEND   = 3'd3;
   localparam kind_type KIND_ACK      = 3'd4;

   // One result before the identity fields are attached
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  pkt;
      logic [31:0] mask;
      logic        complete;
   } result_type;

endpackage

[design/burst_reassembly_tracker.sv]
// Burst reassembly tracker.
// req_* carries parsed link items: burst headers, end markers, packet
// verdicts and quiet ticks (command in req_tuser). rsp_* carries zero or more
// results per item: assemble orders, first-burst and missing-burst requests,
// resends and acknowledgements; rsp_tlast marks the last result of an item.
// Per-packet burst bitmaps and counts live in one memory with a registered
// read; every per-packet step is a read, then a modify and write.
// Items are handled one at a time. Dropped burst headers skip the memory.
// A completed end marker for a packet above zero starts a cascade scan of
// the lower packets; quiet ticks scan the open packets, or do nothing when
// there is nothing to do. Done packets are passed over in a scan without
// a modify step. The single memory read port sets the order of these steps.
// Results pass through a one-deep holding register and an output register.
// A stalled receiver holds rsp_tdata; the block stalls only when both the
// holding and output registers are full, and it takes the next item while
// the final result still waits on rsp_tready.
// Synchronous reset clears all tracking state; the memory uses valid bits,
// so no clearing pass is needed.
`include "burst_reassembly_tracker_macros.svh"
module burst_reassembly_tracker import brt_pkg::*; #(
   parameter int PACKETS = 32,
   parameter int BURSTS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // crc_ok, sender_serial, profile_number, packet_index, burst_index,
   // burst_total, verdict_ok, total_packets
   input  logic [55:0] req_tdata,
   input  logic [2:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_packet, missing_mask, out_serial, out_profile, profile_complete
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // kind
   output logic        rsp_tlast   // last
);

   localparam int AW = $clog2(PACKETS);
   localparam int QW = AW + 1;
   localparam int BW = $clog2(BURSTS);
   localparam int CW = $clog2(BURSTS);
   localparam int EW = BURSTS + 2 * CW;
   localparam int MW = (BURSTS < 32) ? BURSTS : 32;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_MOD, S_ONE, S_SCAN, S_SCAN_MOD, S_FIN
   } state_type;

   // Input field split
   logic        in_crc, in_vok;
   logic [13:0] in_ser;
   logic [15:0] in_prof;
   logic [4:0]  in_pkt, in_bst, in_tot, in_tpk;
   cmd_type     in_cmd;
   assign in_crc  = req_tdata[0];
   assign in_ser  = req_tdata[14:1];
   assign in_prof = req_tdata[30:15];
   assign in_pkt  = req_tdata[35:31];
   assign in_bst  = req_tdata[40:36];
   assign in_tot  = req_tdata[45:41];
   assign in_vok  = req_tdata[46];
   assign in_tpk  = req_tdata[51:47];
   assign in_cmd  = req_tuser;

   state_type    state_ff;
   cmd_type      cmd_ff;
   logic [AW-1:0] pkt_ff;
   logic [BW-1:0] bst_ff;
   logic [CW-1:0] tot_ff;
   logic [QW-1:0] q_ff;
   logic         settle_ff;
   kind_type     one_kind_ff;
   logic [4:0]   one_pkt_ff;
   logic [13:0]  lk_ser_ff;
   logic [15:0]  lk_prof_ff;
   logic [AW-1:0] pn_ff, pr_ff;
   logic [PACKETS-1:0] done_ff;
   result_type   pend_ff;
   logic         pend_v_ff;
   logic         rsp_v_ff;
   result_type   rsp_ff;
   logic         rsp_last_ff;
   logic [13:0]  rsp_ser_ff;
   logic [15:0]  rsp_prof_ff;

   // Memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   brt_entry_mem #(.DEPTH(PACKETS), .WIDTH(EW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entry decode
   logic [BURSTS-1:0] e_seen;
   logic [CW-1:0]     e_need, e_recv;
   logic              e_complete;
   logic [31:0]       e_mask;
   assign {e_seen, e_need, e_recv} = rd_data;
   assign e_complete = (e_need != '0) && (e_need == e_recv);

   always_comb begin
      e_mask = '0;
      for (int i = 1; i < MW; i++) begin
         if ((i <= int'(e_need)) && !e_seen[i]) begin
            e_mask[i] = 1'b1;
         end
      end
   end

   // Accept-side checks
   logic accept, lk_zero, id_match, p_ok, link_ok, prof_done;
   assign accept    = req_tvalid && req_tready;
   assign lk_zero   = (lk_ser_ff == '0) && (lk_prof_ff == '0);
   assign id_match  = lk_zero || ((in_ser == lk_ser_ff) && (in_prof == lk_prof_ff));
   assign p_ok      = 32'(in_pkt) < PACKETS;
   assign link_ok   = in_crc && p_ok && id_match;
   assign prof_done = (pn_ff != '0) && (pr_ff >= pn_ff);
   assign req_tready = (state_ff == S_IDLE);

   logic slot_free, emit_ok;
   assign slot_free = !rsp_v_ff || rsp_tready;
   assign emit_ok   = !pend_v_ff || slot_free;

   logic [AW-1:0] q_idx;
   assign q_idx = q_ff[AW-1:0];
   assign rd_addr = (state_ff == S_SCAN || state_ff == S_SCAN_MOD) ? q_idx : pkt_ff;

   // Per-state result and write-back decision
   logic       do_emit;
   result_type new_res;
   logic       scan_end;
   always_comb begin
      do_emit = 1'b0;
      new_res = '{kind: KIND_ASSEMBLE, pkt: 5'(pkt_ff), mask: '0, complete: prof_done};
      wr_en   = 1'b0;
      wr_addr = pkt_ff;
      wr_data = rd_data;
      scan_end = settle_ff ? (q_ff > QW'(pn_ff)) : (q_ff >= QW'(pkt_ff));
      unique case (state_ff)
         S_MOD: begin
            unique case (cmd_ff)
               CMD_FIRST: begin
                  wr_en   = !e_seen[0];
                  wr_data = {e_seen | BURSTS'(1), tot_ff, e_recv};
               end
               CMD_DATA: begin
                  wr_en   = !e_seen[bst_ff];
                  wr_data = {e_seen | (BURSTS'(1) << bst_ff), e_need, e_recv + CW'(1)};
               end
               default: begin
                  do_emit = 1'b1;
                  if (e_complete) begin
                     wr_en   = 1'b1;
                     wr_data = '0;
                  end else if (e_need == '0) begin
                     new_res.kind = KIND_FIRST;
                  end else begin
                     new_res.kind = KIND_MISSING;
                     new_res.mask = e_mask;
                     do_emit      = (e_mask != '0);
                  end
               end
            endcase
         end
         S_ONE: begin
            do_emit      = 1'b1;
            new_res.kind = one_kind_ff;
            new_res.pkt  = one_pkt_ff;
         end
         S_SCAN_MOD: begin
            new_res.pkt = 5'(q_ff);
            wr_addr     = q_idx;
            wr_data     = '0;
            if (e_complete) begin
               do_emit = 1'b1;
               wr_en   = emit_ok;
            end else if (settle_ff && (e_need == '0)) begin
               do_emit      = 1'b1;
               new_res.kind = KIND_FIRST;
            end else if (settle_ff && (e_mask != '0)) begin
               do_emit      = 1'b1;
               new_res.kind = KIND_MISSING;
               new_res.mask = e_mask;
            end
         end
         default: ;
      endcase
   end

   // Output register loads from the holding register
   logic rsp_load;
   assign rsp_load = (do_emit && emit_ok && pend_v_ff)
                     || ((state_ff == S_FIN) && pend_v_ff && slot_free);

   // Sequencer, tracking registers and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         lk_ser_ff  <= '0;
         lk_prof_ff <= '0;
         pn_ff      <= '0;
         pr_ff      <= '0;
         done_ff    <= '0;
         pend_v_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         // Holding register: push older result out when a new one comes
         if (do_emit && emit_ok) begin
            if (pend_v_ff) begin
               rsp_ff      <= pend_ff;
               rsp_last_ff <= 1'b0;
               rsp_ser_ff  <= lk_ser_ff;
               rsp_prof_ff <= lk_prof_ff;
            end
            pend_ff   <= new_res;
            pend_v_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff   <= in_cmd;
                  pkt_ff   <= AW'(in_pkt);
                  bst_ff   <= BW'(in_bst);
                  tot_ff   <= CW'(in_tot);
                  settle_ff <= 1'b1;
                  q_ff     <= QW'(1);
                  case (in_cmd)
                     CMD_FIRST, CMD_DATA, CMD_END: begin
                        if (in_crc && p_ok && lk_zero) begin
                           lk_ser_ff  <= in_ser;
                           lk_prof_ff <= in_prof;
                        end
                        if (link_ok && ((in_cmd == CMD_END)
                              || ((in_cmd == CMD_FIRST) && (32'(in_tot) < BURSTS))
                              || ((in_cmd == CMD_DATA) && (in_bst != '0)
                                  && (32'(in_bst) < BURSTS)))) begin
                           state_ff <= S_RD;
                        end
                     end
                     CMD_VERDICT: begin
                        if (p_ok) begin
                           one_pkt_ff <= in_pkt;
                           state_ff   <= S_ONE;
                           if (!in_vok) begin
                              one_kind_ff <= KIND_RESEND;
                           end else begin
                              one_kind_ff <= KIND_ACK;
                              done_ff[AW'(in_pkt)] <= 1'b1;
                              if (in_pkt == '0) begin
                                 pn_ff <= (32'(in_tpk) < PACKETS - 1) ? AW'(in_tpk)
                                                                      : AW'(PACKETS - 1);
                              end else if (!done_ff[AW'(in_pkt)]) begin
                                 pr_ff <= pr_ff + AW'(1);
                              end
                           end
                        end
                     end
                     CMD_QUIET: begin
                        if ((pn_ff == '0) && (pr_ff != '0)) begin
                           one_kind_ff <= KIND_RESEND;
                           one_pkt_ff  <= '0;
                           state_ff    <= S_ONE;
                        end else if ((pn_ff != '0) && (pr_ff < pn_ff)) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: state_ff <= S_MOD;
            S_MOD: begin
               if (cmd_ff == CMD_FIRST || cmd_ff == CMD_DATA) begin
                  state_ff <= S_IDLE;
               end else if (e_complete && (pkt_ff != '0)) begin
                  settle_ff <= 1'b0;
                  q_ff      <= '0;
                  state_ff  <= S_SCAN;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_ONE: begin
               if (emit_ok) begin
                  state_ff <= S_FIN;
               end
            end
            S_SCAN: begin
               if (scan_end) begin
                  state_ff <= S_FIN;
               end else if (done_ff[q_idx]) begin
                  q_ff <= q_ff + QW'(1);
               end else begin
                  state_ff <= S_SCAN_MOD;
               end
            end
            S_SCAN_MOD: begin
               if (!do_emit || emit_ok) begin
                  q_ff     <= q_ff + QW'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_FIN: begin
               if (!pend_v_ff) begin
                  state_ff <= S_IDLE;
               end else if (slot_free) begin
                  rsp_ff      <= pend_ff;
                  rsp_last_ff <= 1'b1;
                  rsp_ser_ff  <= lk_ser_ff;
                  rsp_prof_ff <= lk_prof_ff;
                  pend_v_ff   <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Output packing
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.complete, rsp_prof_ff, rsp_ser_ff,
                        rsp_ff.mask, rsp_ff.pkt};

   // Checks
   `BRT_ASSERT_NOW(a_idle_no_pend, clock, reset, state_ff == S_IDLE, !pend_v_ff,
      "result held back while idle")
   `BRT_ASSERT_NEXT(a_pr_only_on_accept, clock, reset, !accept, $stable(pr_ff),
      "packet count moved without an accepted transfer")
   `BRT_ASSERT_NEXT(a_lock_only_on_accept, clock, reset, !accept,
      $stable(lk_ser_ff) && $stable(lk_prof_ff), "identity lock moved outside a transfer")

endmodule

[design/brt_entry_mem.sv]
module brt_entry_mem import brt_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 42
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] raw_ff;
   logic             rvld_ff;

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff <= mem[rd_addr];
   end

   assign rd_data = rvld_ff ? raw_ff : '0;

endmodule
